// File: rtl/rrhr_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the R-R interval heart-rate classifier.
package rrhr_pkg;

  localparam int PEAK_W  = 32;
  localparam int BPM_W   = 16;
  localparam int CLASS_W = 2;
  localparam int TICK_W  = 10;
  localparam int LIMIT_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // delta is at most 60000 (16 bits) when multiplied, tick period 10 bits
  localparam int DELTA_MUL_W = 16;
  localparam int MS_W        = DELTA_MUL_W + TICK_W;
  localparam int DIV_CNT_W   = 4;

  localparam logic [BPM_W-1:0] MS_PER_MINUTE = 16'd60000;

  localparam logic [CLASS_W-1:0] CLASS_NORMAL = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_BRADY  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_TACHY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT  = 2'd2;

  localparam logic [TICK_W-1:0]  TICK_PERIOD_RST = 10'd1;
  localparam logic [LIMIT_W-1:0] SLOW_LIMIT_RST  = 8'd50;
  localparam logic [LIMIT_W-1:0] FAST_LIMIT_RST  = 8'd130;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic take;      // capture peak, update reference
    logic mul;       // form interval ms, init divider
    logic div_step;  // one restoring division step
    logic load_out;  // load result register
  } ctl_cmd_t;

  typedef struct packed {
    logic have_ref;  // a reference peak is held
    logic skip;      // zero interval: no result
    logic div_last;  // final division step this cycle
    logic out_busy;  // result register still held
  } dp_status_t;

endpackage

// File: rtl/rrhr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for peak items and result items.
interface rrhr_in_if;
  import rrhr_pkg::*;
  logic              valid;
  logic              ready;
  logic [PEAK_W-1:0] peak_time;
  modport source (output valid, output peak_time, input ready);
  modport sink   (input valid, input peak_time, output ready);
endinterface

interface rrhr_out_if;
  import rrhr_pkg::*;
  logic               valid;
  logic               ready;
  logic [BPM_W-1:0]   bpm;
  logic [CLASS_W-1:0] rhythm_class;
  modport source (output valid, output bpm, output rhythm_class, input ready);
  modport sink   (input valid, input bpm, input rhythm_class, output ready);
endinterface

// File: rtl/rrhr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing capture, multiply, divide and output.
module rrhr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rrhr_pkg::dp_status_t  status,
  output rrhr_pkg::ctl_cmd_t    cmd
);
  import rrhr_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && status.have_ref) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = status.skip ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_OUT: cmd.load_out = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/rrhr_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, reference time, multiplier, divider, result register.
module rrhr_datapath #(
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rrhr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrhr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [rrhr_pkg::PEAK_W-1:0]        in_peak_time,
  input  rrhr_pkg::ctl_cmd_t                 cmd,
  output rrhr_pkg::dp_status_t               status,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [rrhr_pkg::BPM_W-1:0]         out_bpm,
  output logic [rrhr_pkg::CLASS_W-1:0]       out_rhythm_class
);
  import rrhr_pkg::*;

  logic [TICK_W-1:0]    tick_r;
  logic [LIMIT_W-1:0]   slow_r;
  logic [LIMIT_W-1:0]   fast_r;
  logic [TIME_BITS-1:0] prev_r;
  logic                 have_ref_r;
  logic [TIME_BITS-1:0] delta_r;
  logic [MS_W-1:0]      ms_r;
  logic [MS_W-1:0]      rem_r;
  logic [BPM_W-1:0]     quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic [BPM_W-1:0]     bpm_r;
  logic [CLASS_W-1:0]   class_r;

  logic [TIME_BITS-1:0] now;
  logic [MS_W:0]        rem_sh;
  logic [MS_W:0]        rem_diff;
  logic                 quot_bit;
  logic [CLASS_W-1:0]   class_nxt;

  assign now = TIME_BITS'(in_peak_time);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_PERIOD_RST;
      slow_r <= SLOW_LIMIT_RST;
      fast_r <= FAST_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_PERIOD: tick_r <= cfg_wdata[TICK_W-1:0];
        REG_SLOW_LIMIT:  slow_r <= cfg_wdata[LIMIT_W-1:0];
        REG_FAST_LIMIT:  fast_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // reference time and interval
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_ref_r <= 1'b0;
    end else if (cmd.take) begin
      have_ref_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prev_r  <= now;
      delta_r <= now - prev_r;
    end
  end

  // interval in ms; long intervals saturate so the quotient comes out zero
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      if (delta_r > TIME_BITS'(MS_PER_MINUTE)) begin
        ms_r <= '1;
      end else begin
        ms_r <= MS_W'(delta_r[DELTA_MUL_W-1:0]) * MS_W'(tick_r);
      end
    end
  end

  // restoring divider: 60000 / ms, one quotient bit a cycle
  assign rem_sh   = {rem_r, quot_r[BPM_W-1]};
  assign rem_diff = rem_sh - {1'b0, ms_r};
  assign quot_bit = !rem_diff[MS_W];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r  <= '0;
      quot_r <= MS_PER_MINUTE;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= quot_bit ? rem_diff[MS_W-1:0] : rem_sh[MS_W-1:0];
      quot_r <= {quot_r[BPM_W-2:0], quot_bit};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // brady test first, it wins over crossed limits
  always_comb begin
    priority if (quot_r < BPM_W'(slow_r)) begin
      class_nxt = CLASS_BRADY;
    end else if (quot_r > BPM_W'(fast_r)) begin
      class_nxt = CLASS_TACHY;
    end else begin
      class_nxt = CLASS_NORMAL;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      bpm_r   <= quot_r;
      class_r <= class_nxt;
    end
  end

  assign status.have_ref = have_ref_r;
  assign status.skip     = (delta_r == '0) || (tick_r == '0);
  assign status.div_last = (cnt_r == '1);
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_bpm          = bpm_r;
  assign out_rhythm_class = class_r;

endmodule

// File: rtl/rr_interval_heart_rate_classifier.sv
`timescale 1ns / 1ps
// Top level of the R-R interval heart-rate classifier.
//
//   channel   dir  handshake        payload
//   in_chan   in   valid/ready      peak_time[31:0]
//   out_chan  out  valid/ready      bpm[15:0], rhythm_class[1:0]
//   cfg       in   cfg_we strobe    cfg_index[1:0], cfg_wdata[9:0]
//
// One item at a time. A first peak only sets the reference; a zero interval or
// zero tick period ends at multiply. A peak with a result goes through capture,
// multiply, 16 restoring divider steps at one bit per cycle and the result load.
// Synchronous active-low reset clears the reference flag and loads the register
// defaults. A stalled result holds in the output register; the next item is
// accepted meanwhile and waits at the result load until the register frees.
module rr_interval_heart_rate_classifier #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rrhr_in_if.sink                         in_chan,
  rrhr_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [rrhr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrhr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rrhr_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  // sequence the item through capture, multiply, divide and output
  rrhr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold config, reference and arithmetic
  rrhr_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_peak_time     (in_chan.peak_time),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_bpm          (out_chan.bpm),
    .out_rhythm_class (out_chan.rhythm_class)
  );

  assign in_chan.ready = in_ready;

endmodule

// File: tb/rr_interval_heart_rate_classifier_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the R-R interval heart-rate classifier: directed and random peaks.
module rr_interval_heart_rate_classifier_test;
  import rrhr_pkg::*;

  // Run limits. Each result passes through the block's capture, multiply, divide
  // and load states, and each side stalls in random bursts. With about 1900 items
  // the limit leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 185;

  // Index past the end of the register map: the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [BPM_W-1:0]   bpm;
    logic [CLASS_W-1:0] rhythm_class;
  } heart_rate_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rrhr_in_if  in_chan ();
  rrhr_out_if out_chan ();

  rr_interval_heart_rate_classifier #(
    .TIME_BITS (32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the block's registers and peak reference.
  logic [TICK_W-1:0]  tick_ms;
  logic [LIMIT_W-1:0] brady_below;
  logic [LIMIT_W-1:0] tachy_above;
  logic [PEAK_W-1:0]  last_peak;
  logic               have_last;

  // Heart rates predicted but not yet seen on the result channel, oldest first.
  heart_rate_t expected_rates[$];
  heart_rate_t oldest_rate;

  int                failures    = 0;
  int                cycle_count = 0;
  int                gap_pct     = 20;  // chance in percent of a gap before an item
  bit                quiet       = 1'b0;  // set for the final phase: no stalls either side
  logic [PEAK_W-1:0] stamp       = '0;    // running R-peak timestamp

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_shadow();
    tick_ms     = TICK_PERIOD_RST;
    brady_below = SLOW_LIMIT_RST;
    tachy_above = FAST_LIMIT_RST;
    last_peak   = '0;
    have_last   = 1'b0;
  endfunction

  // Mirror one register write; only the low bits of each register are kept.
  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TICK_PERIOD: tick_ms     = data[TICK_W-1:0];
      REG_SLOW_LIMIT:  brady_below = data[LIMIT_W-1:0];
      REG_FAST_LIMIT:  tachy_above = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // Work out the heart rate caused by one accepted peak, if any, and queue it.
  function automatic void predict_heart_rate(input logic [PEAK_W-1:0] peak);
    logic [PEAK_W-1:0] gap;
    logic [31:0]       interval_ms;
    heart_rate_t       rate;

    // The first peak only sets the reference.
    if (!have_last) begin
      last_peak = peak;
      have_last = 1'b1;
      return;
    end

    // Difference wraps modulo 2^32; the reference moves even when no result follows.
    gap       = peak - last_peak;
    last_peak = peak;
    if (gap == '0 || tick_ms == '0) begin
      return;
    end

    // Anything past a minute reads as 0 bpm; below that the product fits in 32 bits.
    if (gap > 32'(MS_PER_MINUTE)) begin
      rate.bpm = '0;
    end else begin
      interval_ms = gap * 32'(tick_ms);
      rate.bpm    = BPM_W'(32'(MS_PER_MINUTE) / interval_ms);
    end

    // The slow test comes first, so it wins when the limits cross.
    if (rate.bpm < brady_below) begin
      rate.rhythm_class = CLASS_BRADY;
    end else if (rate.bpm > tachy_above) begin
      rate.rhythm_class = CLASS_TACHY;
    end else begin
      rate.rhythm_class = CLASS_NORMAL;
    end
    expected_rates.push_back(rate);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register; the idle cycle after it keeps each write enable pulse clean.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    shadow_write(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one peak and hold it until the block takes it. Valid stays high on
  // return so that back-to-back items need no extra assignment.
  task automatic send_peak(input logic [PEAK_W-1:0] peak);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.peak_time <= peak;
    do @(posedge clk); while (!in_chan.ready);
    predict_heart_rate(peak);
  endtask

  // Advance the running timestamp by a number of ticks and send it.
  task automatic advance_peak(input logic [PEAK_W-1:0] ticks);
    stamp = stamp + ticks;
    send_peak(stamp);
  endtask

  // Drop valid, wait for every expected rate, then give a peak that causes no
  // result time to leave the block before the registers change.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: first peak, repeated timestamp, the one-tick and one-minute
  // extremes, an interval past a minute, both class boundaries and a wrap.
  task automatic test_defaults_and_boundaries();
    stamp = 32'd1000;
    send_peak(stamp);      // first peak: reference only
    advance_peak(32'd1000);  // 60 bpm
    advance_peak(32'd0);     // repeated timestamp
    advance_peak(32'd1);     // fastest possible rate
    advance_peak(32'd60000); // exactly one minute
    advance_peak(32'd60001); // past a minute: 0 bpm
    advance_peak(32'd1200);  // 50 bpm sits on the slow limit
    advance_peak(32'd1201);  // just under it
    advance_peak(32'd460);   // 130 bpm sits on the fast limit
    advance_peak(32'd458);   // just over it
    stamp = 32'hFFFF_FF00;
    send_peak(stamp);        // huge jump toward the top of the counter
    advance_peak(32'h200);   // counter wraps through zero
    settle();
  endtask

  // Largest tick period, limits at 0 and 255, upper data bits that must be
  // dropped, and a write to an index the block does not have.
  task automatic test_register_extremes();
    write_reg(REG_TICK_PERIOD, 10'h3FF);
    write_reg(REG_SLOW_LIMIT, 10'h300);
    write_reg(REG_FAST_LIMIT, 10'h3FF);
    write_reg(REG_UNUSED, 10'h3FF);
    advance_peak(32'd58);
    advance_peak(32'd1);
    advance_peak(32'd60000);
    settle();
    write_reg(REG_TICK_PERIOD, 10'd1000);
    advance_peak(32'd1);
    advance_peak(32'd60);
    settle();
  endtask

  // Slow limit above fast limit: a rate between the two limits classes as bradycardia.
  task automatic test_crossed_limits();
    write_reg(REG_TICK_PERIOD, 10'd1);
    write_reg(REG_SLOW_LIMIT, 10'd200);
    write_reg(REG_FAST_LIMIT, 10'd10);
    advance_peak(32'd300);
    advance_peak(32'd1000);
    advance_peak(32'd301);
    settle();
  endtask

  // Tick period of zero gives no result, yet the reference keeps moving.
  task automatic test_zero_tick_period();
    write_reg(REG_TICK_PERIOD, 10'd0);
    advance_peak(32'd100);
    advance_peak(32'd0);
    advance_peak(32'd500);
    settle();
    write_reg(REG_TICK_PERIOD, 10'd1);
    advance_peak(32'd250);
    settle();
  endtask

  // Phases of random registers. Most intervals are plausible heartbeats with
  // random length; the rest are repeats, very short gaps, gaps around a minute and
  // random jumps that reach every timestamp bit.
  task automatic test_random_rhythm();
    logic [PEAK_W-1:0]  ticks;
    logic [TICK_W-1:0]  period;
    logic [LIMIT_W-1:0] slow;
    logic [LIMIT_W-1:0] fast;
    int                 target_ms;
    int                 pick;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet   = (phase == RANDOM_PHASES - 1);
      gap_pct = (phase % 3 == 1) ? 0 : ((phase % 3 == 2) ? 50 : 20);

      case ($urandom_range(0, 11))
        0:       period = 10'd1;
        1:       period = 10'd1000;
        2:       period = 10'h3FF;
        3:       period = 10'd0;
        4:       period = TICK_W'($urandom_range(1, 1000));
        default: period = TICK_W'($urandom_range(1, 12));
      endcase
      slow = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                         : LIMIT_W'($urandom_range(20, 120));
      fast = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                         : LIMIT_W'($urandom_range(100, 255));
      write_reg(REG_TICK_PERIOD, period);
      write_reg(REG_SLOW_LIMIT, {2'($urandom_range(0, 3)), slow});
      write_reg(REG_FAST_LIMIT, {2'($urandom_range(0, 3)), fast});
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
      end
      if ($urandom_range(0, 1) == 0) begin
        stamp = $urandom();
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          target_ms = $urandom_range(150, 2500);
          ticks     = (tick_ms == '0) ? PEAK_W'(target_ms) : PEAK_W'(target_ms / tick_ms);
          if (ticks == '0) begin
            ticks = 32'd1;
          end
        end else if (pick < 78) begin
          ticks = '0;
        end else if (pick < 85) begin
          ticks = PEAK_W'($urandom_range(1, 20));
        end else if (pick < 92) begin
          ticks = PEAK_W'($urandom_range(55000, 65000));
        end else begin
          ticks = $urandom();
        end
        advance_peak(ticks);
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall the result channel in random bursts, with runs of ready between, some of them long.
  initial begin
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16))
        @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_rates.size() == 0) begin
        $error("unexpected result: bpm %0d rhythm_class %0d", out_chan.bpm, out_chan.rhythm_class);
        failures++;
      end else begin
        oldest_rate = expected_rates.pop_front();
        if (out_chan.bpm !== oldest_rate.bpm) begin
          $error("bpm mismatch: expected %0d, actual %0d", oldest_rate.bpm, out_chan.bpm);
          failures++;
        end
        if (out_chan.rhythm_class !== oldest_rate.rhythm_class) begin
          $error("rhythm_class mismatch: expected %0d, actual %0d",
                 oldest_rate.rhythm_class, out_chan.rhythm_class);
          failures++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_TICK_PERIOD;
    cfg_wdata         <= '0;
    in_chan.valid     <= 1'b0;
    in_chan.peak_time <= '0;
    reset_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults_and_boundaries();
    test_register_extremes();
    test_crossed_limits();
    test_zero_tick_period();
    test_random_rhythm();

    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
